>>> hw/rtl/u2l_pkg.sv
// Shared types, constants and the code point mapping function of the UTF-8 transcoder.
package u2l_pkg;

  // Replacement character '?'
  localparam logic [7:0] REPL_CHAR = 8'h3F;

  // Values of the code page select register
  localparam logic CP_WIN1252 = 1'b0;
  localparam logic CP_WIN1251 = 1'b1;

  // Register index, taken from the word address of the configuration port
  localparam logic REG_TARGET_CP = 1'b0;

  // Pending sequence depth codes
  localparam logic [1:0] PEND_NONE   = 2'd0;
  localparam logic [1:0] PEND_LEAD   = 2'd1;
  localparam logic [1:0] PEND_SECOND = 2'd2;

  // Depth of the result queue and width of its fill level
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_LW    = $clog2(OUTQ_DEPTH + 1);

  // One result item
  typedef struct packed {
    logic [7:0] code;
    logic       sub;
    logic       run_end;
  } res_t;

  // Results caused by one input request: count and up to two items
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

  // Status of the result queue towards the top level
  typedef struct packed {
    logic               room2;
    logic [OUTQ_LW-1:0] level;
  } q_stat_t;

  // Mapped byte and substitution flag
  typedef struct packed {
    logic [7:0] code;
    logic       sub;
  } map_t;

  // Maps a code point to the selected legacy code page.
  function automatic map_t map_point(input logic [15:0] cp, input logic sel);
    map_t m;
    m.code = REPL_CHAR;
    m.sub  = 1'b1;
    if (cp <= 16'h007F) begin
      m.code = cp[7:0];
      m.sub  = 1'b0;
    end else if (sel == CP_WIN1252) begin
      if (cp >= 16'h00A0 && cp <= 16'h00FF) begin
        m.code = cp[7:0];
        m.sub  = 1'b0;
      end else begin
        m.sub = 1'b0;
        case (cp)
          16'h20AC: m.code = 8'h80;
          16'h201A: m.code = 8'h82;
          16'h0192: m.code = 8'h83;
          16'h201E: m.code = 8'h84;
          16'h2026: m.code = 8'h85;
          16'h2020: m.code = 8'h86;
          16'h2021: m.code = 8'h87;
          16'h02C6: m.code = 8'h88;
          16'h2030: m.code = 8'h89;
          16'h0160: m.code = 8'h8A;
          16'h2039: m.code = 8'h8B;
          16'h0152: m.code = 8'h8C;
          16'h017D: m.code = 8'h8E;
          16'h2018: m.code = 8'h91;
          16'h2019: m.code = 8'h92;
          16'h201C: m.code = 8'h93;
          16'h201D: m.code = 8'h94;
          16'h2022: m.code = 8'h95;
          16'h2013: m.code = 8'h96;
          16'h2014: m.code = 8'h97;
          16'h02DC: m.code = 8'h98;
          16'h2122: m.code = 8'h99;
          16'h0161: m.code = 8'h9A;
          16'h203A: m.code = 8'h9B;
          16'h0153: m.code = 8'h9C;
          16'h017E: m.code = 8'h9E;
          16'h0178: m.code = 8'h9F;
          default: begin
            m.code = REPL_CHAR;
            m.sub  = 1'b1;
          end
        endcase
      end
    end else begin
      // Cyrillic block U+0410..U+044F lands on 0xC0..0xFF
      if (cp >= 16'h0410 && cp <= 16'h044F) begin
        m.code = cp[7:0] + 8'hB0;
        m.sub  = 1'b0;
      end else if (cp == 16'h0401) begin
        m.code = 8'hA8;
        m.sub  = 1'b0;
      end else if (cp == 16'h0451) begin
        m.code = 8'hB8;
        m.sub  = 1'b0;
      end
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/u2l_decode.sv
// UTF-8 sequence decoder with its pending-byte state and code page mapping.
module u2l_decode import u2l_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  input  logic       codepage,
  output dec_out_t   dec,
  output logic       pend_busy
);

  logic [7:0] lead_r, lead_nxt;
  logic [7:0] second_r, second_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       is_lead;
  logic [15:0] cp;
  map_t       m;

  // A byte that opens a two- or three-byte sequence
  assign is_lead = (byte_in[7:5] == 3'b110) || (byte_in[7:4] == 4'b1110);

  // Assemble the code point of a sequence that completes with this byte
  always_comb begin
    if (cnt_r == PEND_SECOND) begin
      cp = {lead_r[3:0], second_r[5:0], byte_in[5:0]};
    end else begin
      cp = {5'd0, lead_r[4:0], byte_in[5:0]};
    end
  end

  assign m = map_point(cp, codepage);

  // Result selection and next pending state
  always_comb begin
    dec        = '0;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    cnt_nxt    = cnt_r;
    case (cnt_r)
      PEND_LEAD: begin
        if (lead_r[7:5] == 3'b110) begin
          dec.num     = 2'd1;
          dec.r0.code = m.code;
          dec.r0.sub  = m.sub;
          cnt_nxt     = PEND_NONE;
        end else if (last_in) begin
          // Stream ended after two bytes of three: lead fails, byte redone as lead
          dec.num     = 2'd2;
          dec.r0.code = REPL_CHAR;
          dec.r0.sub  = 1'b1;
          dec.r1.code = byte_in[7] ? REPL_CHAR : byte_in;
          dec.r1.sub  = byte_in[7];
          cnt_nxt     = PEND_NONE;
        end else begin
          second_nxt = byte_in;
          cnt_nxt    = PEND_SECOND;
        end
      end
      PEND_SECOND: begin
        dec.num     = 2'd1;
        dec.r0.code = m.code;
        dec.r0.sub  = m.sub;
        cnt_nxt     = PEND_NONE;
      end
      default: begin
        cnt_nxt = PEND_NONE;
        if (!byte_in[7]) begin
          dec.num     = 2'd1;
          dec.r0.code = byte_in;
        end else if (is_lead && !last_in) begin
          lead_nxt = byte_in;
          cnt_nxt  = PEND_LEAD;
        end else begin
          dec.num     = 2'd1;
          dec.r0.code = REPL_CHAR;
          dec.r0.sub  = 1'b1;
        end
      end
    endcase
    if (last_in) begin
      cnt_nxt = PEND_NONE;
    end
    // Mark the final result of this request
    dec.r0.run_end = (dec.num == 2'd1);
    dec.r1.run_end = (dec.num == 2'd2);
  end

  // Pending sequence registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= PEND_NONE;
    end else if (go) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      lead_r   <= lead_nxt;
      second_r <= second_nxt;
    end
  end

  assign pend_busy = (cnt_r != PEND_NONE);

endmodule

>>> hw/rtl/u2l_outq.sv
// Result queue that takes up to two results a cycle and hands out one.
module u2l_outq import u2l_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dec_out_t push,
  input  logic     push_en,
  input  logic     pop,
  output logic     valid,
  output res_t     head,
  output q_stat_t  stat
);

  localparam int AW = $clog2(OUTQ_DEPTH);
  localparam int CW = OUTQ_LW;

  res_t          mem [OUTQ_DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    n_in;
  logic          do_pop;

  assign n_in   = push_en ? push.num : 2'd0;
  assign do_pop = pop && (cnt_r != '0);

  // Pointer and fill level update
  always_comb begin
    wr_nxt  = wr_r + AW'(n_in);
    rd_nxt  = rd_r + AW'(do_pop);
    cnt_nxt = cnt_r + CW'(n_in) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage writes: first result at the write pointer, second just after
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wr_r] <= push.r0;
    end
    if (n_in == 2'd2) begin
      mem[wr_r + AW'(1)] <= push.r1;
    end
  end

  assign valid      = (cnt_r != '0);
  assign head       = mem[rd_r];
  assign stat.room2 = (32'(cnt_r) + 2 <= OUTQ_DEPTH);
  assign stat.level = cnt_r;

endmodule

>>> hw/rtl/utf8_to_legacy_codepage.sv
// Top level of the UTF-8 to Windows-1252/1251 transcoder.
// A byte is held in the input register, then decoded and mapped into the result queue,
// whose head drives out_valid. Throughput: one byte per cycle while the queue has room
// for two results, also for a byte that yields two; the four-entry queue sets how long
// a stalled output can be absorbed. Reset (rst_n, synchronous, active low) clears the
// queue, the pending sequence and selects Windows-1252.
module utf8_to_legacy_codepage import u2l_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_substituted,
  output logic        out_run_end,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic       cp_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_go;
  logic       in_fire;
  logic       cfg_wr;
  logic       pend_busy;
  dec_out_t   dec;
  res_t       head;
  q_stat_t    qstat;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r <= CP_WIN1252;
    end else if (cfg_wr && cfg_paddr[2] == REG_TARGET_CP) begin
      cp_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TARGET_CP) ? {31'd0, cp_r} : 32'd0;

  // Input register: moves on when the queue has room for two results
  assign s1_go    = s1_valid_r && qstat.room2;
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  // Decode and map
  u2l_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (s1_go),
    .byte_in   (s1_byte_r),
    .last_in   (s1_last_r),
    .codepage  (cp_r),
    .dec       (dec),
    .pend_busy (pend_busy)
  );

  // Result queue
  u2l_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (dec),
    .push_en (s1_go),
    .pop     (out_ready),
    .valid   (out_valid),
    .head    (head),
    .stat    (qstat)
  );

  assign out_byte        = head.code;
  assign out_substituted = head.sub;
  assign out_run_end     = head.run_end;

  // The queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(qstat.level) <= OUTQ_DEPTH)
    else $error("result queue overfilled");

  // A byte flagged as last leaves no sequence pending
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> !pend_busy)
    else $error("sequence still pending after end of stream");

  // A substituted result always carries the replacement character
  a_sub_repl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_substituted) |-> (out_byte == REPL_CHAR))
    else $error("substitution without replacement character");

  // A stalled input register holds while the queue lacks room
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !qstat.room2) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("input register lost a stalled byte");

endmodule
